### sv/pib_pkg.sv
// Shared constants, types and codes for the pulse-interval BPM averager.
package pib_pkg;

    // Field and register widths
    localparam int SAMPLE_W   = 16;
    localparam int TPM_W      = 20;
    localparam int COUNT_W    = 20;
    localparam int SUM_W      = 30;
    localparam int BPM_W      = 27;
    localparam int LAST_W     = 20;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 2;

    // Register reset values
    localparam logic [SAMPLE_W-1:0] HIGH_RST = 16'd53022;
    localparam logic [SAMPLE_W-1:0] LOW_RST  = 16'd29790;
    localparam logic [TPM_W-1:0]    TPM_RST  = 20'd60000;

    // Saturation limits
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [BPM_W-1:0]   BPM_MAX   = {BPM_W{1'b1}};

    // Rate divider: (tpm << 8) / interval, one quotient bit per cycle
    localparam int Q8_SHIFT = 8;
    localparam int DVD_W    = TPM_W + Q8_SHIFT;
    localparam int STEP_W   = $clog2(DVD_W);

    // Averaging over AVG_COUNT intervals, division by reciprocal multiply
    localparam int AVG_COUNT  = 5;
    localparam int IDX_W      = $clog2(AVG_COUNT + 1);
    localparam int AVG_SHIFT  = SUM_W + 4;
    localparam logic [63:0] AVG_RECIP =
        ((64'd1 << AVG_SHIFT) + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT);
    localparam int RECIP_W    = $clog2(AVG_RECIP + 64'd1);
    localparam int PROD_W     = SUM_W + RECIP_W;
    localparam int QUOT_W     = PROD_W - AVG_SHIFT;

    // Interval queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] ticks;
    } t_qword;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIGH = 2'd0,
        CFG_LOW  = 2'd1,
        CFG_TPM  = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ACC,
        ST_AVG,
        ST_OUT
    } t_back_state;

endpackage

### sv/pib_if.sv
// Handshake channel interfaces for sample words and result words.
interface pib_sample_if;
    import pib_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
    modport mon    (input valid, input sample, input ready);
endinterface

interface pib_result_if;
    import pib_pkg::*;
    logic              valid;
    logic              ready;
    logic [BPM_W-1:0]  bpm_q8;
    logic [LAST_W-1:0] last_interval;

    modport source (output valid, output bpm_q8, output last_interval, input ready);
    modport sink   (input valid, input bpm_q8, input last_interval, output ready);
    modport mon    (input valid, input bpm_q8, input last_interval, input ready);
endinterface

### sv/pib_front.sv
// Front end: peak detection, interval counting, interval push into the queue.
module pib_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [pib_pkg::SAMPLE_W-1:0]  i_high_thr,
    input  logic [pib_pkg::SAMPLE_W-1:0]  i_low_thr,
    input  logic                          i_q_full,
    pib_sample_if.sink                    i_smp,
    output pib_pkg::t_qword               o_push
);
    import pib_pkg::*;

    logic               r_counting, n_counting;
    logic               r_above, n_above;
    logic [COUNT_W-1:0] r_count, n_count;

    logic accept, above_hi, below_lo, start, finish, rearm;

    assign i_smp.ready = !i_q_full;
    assign accept      = i_smp.valid && !i_q_full;

    // Classify the sample
    assign above_hi = i_smp.sample > i_high_thr;
    assign below_lo = i_smp.sample < i_low_thr;
    assign start    = above_hi && !r_above && !r_counting;
    assign finish   = above_hi && !r_above && r_counting;
    assign rearm    = !above_hi && below_lo && r_above && r_counting
                    || above_hi && r_above && below_lo && r_counting;

    // Next state of the counter and flags
    always_comb begin
        n_counting = r_counting;
        n_above    = r_above;
        n_count    = r_count;
        if (start) begin
            n_counting = 1'b1;
            n_above    = 1'b1;
        end else if (finish) begin
            n_counting = 1'b0;
            n_above    = 1'b0;
            n_count    = '0;
        end else if (rearm) begin
            n_above    = 1'b0;
        end
        if (n_counting && n_count != COUNT_MAX) begin
            n_count = n_count + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counting <= 1'b0;
            r_above    <= 1'b0;
            r_count    <= '0;
        end else if (accept) begin
            r_counting <= n_counting;
            r_above    <= n_above;
            r_count    <= n_count;
        end
    end

    // Finished interval goes to the back end
    assign o_push.valid = accept && finish;
    assign o_push.ticks = r_count;

endmodule

### sv/pib_queue.sv
// Short FIFO of finished interval lengths between front and back.
module pib_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pib_pkg::t_qword i_push,
    input  logic            i_pop,
    output pib_pkg::t_qword o_head,
    output logic            o_full
);
    import pib_pkg::*;

    logic [COUNT_W-1:0] r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr, r_rd;
    logic [QCNT_W-1:0]  r_cnt;
    logic               do_pop;

    assign o_full       = r_cnt == QCNT_W'(QUEUE_DEPTH);
    assign o_head.valid = r_cnt != '0;
    assign o_head.ticks = r_mem[r_rd];
    assign do_pop       = i_pop && o_head.valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.ticks;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            case ({i_push.valid, do_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### sv/pib_back.sv
// Back end: serial rate divider, running sum, average and output register.
module pib_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [pib_pkg::TPM_W-1:0]  i_tpm,
    input  pib_pkg::t_qword            i_head,
    output logic                       o_pop,
    pib_result_if.source               o_res
);
    import pib_pkg::*;

    t_back_state r_state, n_state;

    logic [DVD_W-1:0]   r_quo;
    logic [COUNT_W-1:0] r_rem;
    logic [COUNT_W-1:0] r_dvs;
    logic [STEP_W-1:0]  r_step;
    logic [COUNT_W-1:0] r_last;
    logic [SUM_W-1:0]   r_sum;
    logic [IDX_W-1:0]   r_idx;
    logic [PROD_W-1:0]  r_prod;
    logic               r_ovalid;
    logic [BPM_W-1:0]   r_bpm;
    logic [LAST_W-1:0]  r_olast;

    logic               load, step, acc, avg, out_load, last_rd;
    logic [COUNT_W:0]   trial, diff;
    logic               ge;
    logic [SUM_W:0]     sum_add;
    logic [SUM_W-1:0]   sum_sat;
    logic [RECIP_W-1:0] recip_c;
    logic [QUOT_W-1:0]  quot;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_head.valid) n_state = ST_DIV;
            ST_DIV:  if (r_step == '0) n_state = ST_ACC;
            ST_ACC:  n_state = last_rd ? ST_AVG : ST_IDLE;
            ST_AVG:  n_state = ST_OUT;
            ST_OUT:  if (!r_ovalid || o_res.ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        load     = 1'b0;
        step     = 1'b0;
        acc      = 1'b0;
        avg      = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: load     = i_head.valid;
            ST_DIV:  step     = 1'b1;
            ST_ACC:  acc      = 1'b1;
            ST_AVG:  avg      = 1'b1;
            ST_OUT:  out_load = !r_ovalid || o_res.ready;
            default: ;
        endcase
    end

    assign o_pop   = load;
    assign last_rd = r_idx == IDX_W'(AVG_COUNT - 1);

    // One restoring division step
    assign trial = {r_rem, r_quo[DVD_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = trial >= {1'b0, r_dvs};

    // Saturating accumulate
    assign sum_add = {1'b0, r_sum} + (SUM_W+1)'(r_quo);
    assign sum_sat = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];

    // Average by reciprocal product
    assign recip_c = AVG_RECIP[RECIP_W-1:0];
    assign quot    = r_prod[PROD_W-1:AVG_SHIFT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Divider datapath
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_quo  <= {i_tpm, Q8_SHIFT'(0)};
            r_rem  <= '0;
            r_dvs  <= (i_head.ticks == '0) ? COUNT_W'(1) : i_head.ticks;
            r_last <= i_head.ticks;
            r_step <= STEP_W'(DVD_W - 1);
        end else if (step) begin
            r_quo  <= {r_quo[DVD_W-2:0], ge};
            r_rem  <= ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
            r_step <= r_step - STEP_W'(1);
        end
    end

    // Running sum and interval index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_idx <= '0;
        end else if (acc) begin
            r_sum <= sum_sat;
            r_idx <= last_rd ? r_idx : r_idx + IDX_W'(1);
        end else if (avg) begin
            r_sum <= '0;
            r_idx <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (avg) begin
            r_prod <= PROD_W'(r_sum) * PROD_W'(recip_c);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_bpm   <= (quot > QUOT_W'(BPM_MAX)) ? BPM_MAX : quot[BPM_W-1:0];
            r_olast <= LAST_W'(r_last);
        end
    end

    assign o_res.valid         = r_ovalid;
    assign o_res.bpm_q8        = r_bpm;
    assign o_res.last_interval = r_olast;

endmodule

### sv/pulse_interval_bpm_averager_top.sv
// Top level of the pulse-interval BPM averager: config registers and block wiring.
// Path: with the back end idle, a sample word that completes the fifth interval passes
//   through the queue and the load, divide, accumulate, average and output states.
// Throughput: one sample word per cycle while the two-entry interval queue has room;
//   each finished interval holds the back end through load, divide and accumulate,
//   plus average and output when it closes an average, longer while a result waits.
// Reset: synchronous active-low i_rst_n clears counters, sum, queue and output valid,
//   and restores the threshold and ticks-per-minute registers to their defaults.
module pulse_interval_bpm_averager_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pib_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pib_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    pib_sample_if.sink                       i_smp,
    pib_result_if.source                     o_res
);
    import pib_pkg::*;

    logic [SAMPLE_W-1:0] r_high_thr;
    logic [SAMPLE_W-1:0] r_low_thr;
    logic [TPM_W-1:0]    r_tpm;

    t_qword push, head;
    logic   q_full, pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_thr <= HIGH_RST;
            r_low_thr  <= LOW_RST;
            r_tpm      <= TPM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HIGH: r_high_thr <= i_cfg_data[SAMPLE_W-1:0];
                CFG_LOW:  r_low_thr  <= i_cfg_data[SAMPLE_W-1:0];
                CFG_TPM:  r_tpm      <= i_cfg_data[TPM_W-1:0];
                default:  ;
            endcase
        end
    end

    pib_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_high_thr (r_high_thr),
        .i_low_thr  (r_low_thr),
        .i_q_full   (q_full),
        .i_smp      (i_smp),
        .o_push     (push)
    );

    pib_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full)
    );

    pib_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tpm   (r_tpm),
        .i_head  (head),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

### sv/pib_checker.sv
// Port-level checker for the pulse-interval BPM averager, bound to the top level.
module pib_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    pib_sample_if.sink   i_smp,
    pib_result_if.source o_res
);
    import pib_pkg::*;

    // A stalled result word holds its value
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=> o_res.valid && $stable(o_res.bpm_q8)
            && $stable(o_res.last_interval))
        else $error("result word changed while stalled");

    // No result word right after reset
    a_res_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_res.valid)
        else $error("result valid right after reset");

    // Input backpressure only appears after an accepted sample word
    a_rdy_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_smp.ready) |-> $past(i_smp.valid && i_smp.ready))
        else $error("ready dropped without an accepted word");

    // A completed interval is never empty
    a_last_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.last_interval != '0)
        else $error("zero-length interval reported");

endmodule

bind pulse_interval_bpm_averager_top pib_checker u_pib_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_smp   (i_smp),
    .o_res   (o_res)
);

### tb/sv/testbench.sv
// Self-checking testbench for the pulse-interval BPM averager top level.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pib_pkg::*;

    // Index outside the register map; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    // Cycles to let in-flight intervals clear the divider before a write
    localparam int DRAIN_CYCLES  = 128;
    localparam int ITEM_TARGET   = 1900;

    typedef struct packed {
        logic [BPM_W-1:0]  bpm_q8;
        logic [LAST_W-1:0] last_interval;
    } bpm_word_t;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [SAMPLE_W-1:0]   sample;
        logic                  pinned;
        bpm_word_t             want;
    } plan_row_t;

    typedef enum int {
        PROF_TPM_ZERO, PROF_TPM_MAX, PROF_TPM_ONE, PROF_TPM_TOP, PROF_HIGH_ZERO,
        PROF_LOW_FULL, PROF_SWAPPED, PROF_NO_PEAK, PROF_NO_REARM, PROF_NORMAL
    } cfg_profile_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    pib_sample_if smp_if ();
    pib_result_if res_if ();

    pulse_interval_bpm_averager_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_smp      (smp_if),
        .o_res      (res_if)
    );

    // Predictor copy of registers and state
    logic [SAMPLE_W-1:0] thr_hi        = HIGH_RST;
    logic [SAMPLE_W-1:0] thr_lo        = LOW_RST;
    logic [TPM_W-1:0]    tpm           = TPM_RST;
    bit                  in_interval   = 1'b0;
    bit                  peak_latched  = 1'b0;
    logic [COUNT_W-1:0]  tick_cnt      = '0;
    int                  beats_seen    = 0;
    logic [SUM_W-1:0]    rate_acc      = '0;

    bpm_word_t   bpm_expect_q[$];
    plan_row_t   plan[$];
    bit          calm = 1'b0;
    int          n_fail = 0;
    int          sent_items = 0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // One tick of the averager: peak detect, interval close, five-beat average
    task automatic predict_bpm(input logic [SAMPLE_W-1:0] s, output bit hit,
                               output bpm_word_t w);
        logic [47:0]        rate;
        logic [47:0]        acc;
        logic [COUNT_W-1:0] divisor;
        hit = 1'b0;
        w   = '0;
        if (s > thr_hi && !peak_latched && !in_interval) begin
            in_interval  = 1'b1;
            peak_latched = 1'b1;
        end else if (s > thr_hi && !peak_latched && in_interval) begin
            divisor  = (tick_cnt == '0) ? COUNT_W'(1) : tick_cnt;
            rate     = ({28'd0, tpm} << Q8_SHIFT) / divisor;
            acc      = rate + rate_acc;
            rate_acc = (acc > SUM_MAX) ? SUM_MAX : acc[SUM_W-1:0];
            beats_seen++;
            if (beats_seen >= AVG_COUNT) begin
                acc             = rate_acc / AVG_COUNT;
                w.bpm_q8        = (acc > BPM_MAX) ? BPM_MAX : acc[BPM_W-1:0];
                w.last_interval = tick_cnt;
                hit             = 1'b1;
                rate_acc        = '0;
                beats_seen      = 0;
            end
            tick_cnt     = '0;
            in_interval  = 1'b0;
            peak_latched = 1'b0;
        end else if (s < thr_lo && peak_latched && in_interval) begin
            peak_latched = 1'b0;
        end
        if (in_interval && tick_cnt != COUNT_MAX) tick_cnt++;
    endtask

    // Drive one sample word, wait for acceptance, record what it should produce
    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit pinned = 1'b0,
                               input bpm_word_t pinned_word = '0);
        bit        hit;
        bpm_word_t w;
        if (!calm && $urandom_range(99, 0) < 11) begin
            @(negedge clk);
            smp_if.valid <= 1'b0;
        end
        @(negedge clk);
        smp_if.valid  <= 1'b1;
        smp_if.sample <= s;
        @(posedge clk);
        while (!smp_if.ready) @(posedge clk);
        predict_bpm(s, hit, w);
        if (pinned) begin
            bpm_expect_q.push_back(pinned_word);
        end else if (hit) begin
            bpm_expect_q.push_back(w);
        end
        sent_items++;
    endtask

    // Stop sending, wait for all results and for the divider to go quiet
    task automatic drain_block();
        @(negedge clk);
        smp_if.valid <= 1'b0;
        while (bpm_expect_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_HIGH: thr_hi = data[SAMPLE_W-1:0];
            CFG_LOW:  thr_lo = data[SAMPLE_W-1:0];
            CFG_TPM:  tpm    = data;
            default: ;
        endcase
    endtask

    // Sample pickers relative to the current thresholds
    function automatic logic [SAMPLE_W-1:0] peak_sample();
        if (thr_hi == '1) return SAMPLE_W'($urandom);
        return SAMPLE_W'($urandom_range(65535, thr_hi + 1));
    endfunction

    function automatic logic [SAMPLE_W-1:0] trough_sample();
        if (thr_lo == '0) return SAMPLE_W'($urandom);
        return SAMPLE_W'($urandom_range(thr_lo - 1, 0));
    endfunction

    // Well-formed beat: start if idle, ride the peak, rearm, wait, next peak
    task automatic close_interval(input int n_pre, input int n_mid);
        if (!in_interval) send_sample(peak_sample());
        repeat (n_pre) send_sample(SAMPLE_W'($urandom_range(65535, thr_lo)));
        if (peak_latched) send_sample(trough_sample());
        repeat (n_mid) send_sample(SAMPLE_W'($urandom_range(thr_hi, thr_lo)));
        send_sample(peak_sample());
    endtask

    // Result side: random backpressure
    always @(negedge clk) begin
        res_if.ready <= calm || ($urandom_range(99, 0) >= 11);
    end

    // Result checker
    always @(posedge clk) begin : result_check
        bpm_word_t want;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (bpm_expect_q.size() == 0) begin
                $error("result word with nothing pending: bpm_q8 %0d last_interval %0d",
                       res_if.bpm_q8, res_if.last_interval);
                n_fail++;
            end else begin
                want = bpm_expect_q.pop_front();
                if (res_if.bpm_q8 !== want.bpm_q8) begin
                    $error("bpm_q8 mismatch: expected %0d, got %0d",
                           want.bpm_q8, res_if.bpm_q8);
                    n_fail++;
                end
                if (res_if.last_interval !== want.last_interval) begin
                    $error("last_interval mismatch: expected %0d, got %0d",
                           want.last_interval, res_if.last_interval);
                    n_fail++;
                end
            end
        end
    end

    initial begin : watchdog
        #100ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        cfg_profile_t        prof;
        logic [SAMPLE_W-1:0] hi;
        logic [SAMPLE_W-1:0] lo;
        logic [TPM_W-1:0]    rate;
        int                  phase_stop;
        int                  n_mid;
        int                  n_phase;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_data      = '0;
        smp_if.valid  = 1'b0;
        smp_if.sample = '0;
        res_if.ready  = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table, reset thresholds first: floor, sample equal to high
        plan.push_back('{ROW_SAMPLE, '0, '0, 16'd0, 1'b0, '0});
        plan.push_back('{ROW_SAMPLE, '0, '0, HIGH_RST, 1'b0, '0});
        // Five two-tick intervals at 60000 ticks/min: 7680000 in Q8
        repeat (4) begin
            plan.push_back('{ROW_SAMPLE, '0, '0, 16'hFFFF, 1'b0, '0});
            plan.push_back('{ROW_SAMPLE, '0, '0, 16'd0, 1'b0, '0});
            plan.push_back('{ROW_SAMPLE, '0, '0, 16'hFFFF, 1'b0, '0});
        end
        plan.push_back('{ROW_SAMPLE, '0, '0, 16'hFFFF, 1'b0, '0});
        plan.push_back('{ROW_SAMPLE, '0, '0, 16'd0, 1'b0, '0});
        plan.push_back('{ROW_SAMPLE, '0, '0, 16'hFFFF, 1'b1, '{27'd7680000, 20'd2}});
        // Dropped write, top rate, swapped thresholds at their extremes
        plan.push_back('{ROW_WRITE, CFG_SPARE, 20'hFFFFF, '0, 1'b0, '0});
        plan.push_back('{ROW_WRITE, CFG_TPM, 20'hFFFFF, '0, 1'b0, '0});
        plan.push_back('{ROW_WRITE, CFG_HIGH, 20'd0, '0, 1'b0, '0});
        plan.push_back('{ROW_WRITE, CFG_LOW, 20'hFFFF, '0, 1'b0, '0});
        plan.push_back('{ROW_SAMPLE, '0, '0, 16'd1, 1'b0, '0});
        plan.push_back('{ROW_SAMPLE, '0, '0, 16'd1, 1'b0, '0});
        plan.push_back('{ROW_SAMPLE, '0, '0, 16'd1, 1'b0, '0});
        plan.push_back('{ROW_SAMPLE, '0, '0, 16'd0, 1'b0, '0});
        plan.push_back('{ROW_SAMPLE, '0, '0, 16'hFFFF, 1'b0, '0});
        // No peak possible, no rearm possible, zero rate
        plan.push_back('{ROW_WRITE, CFG_HIGH, 20'hFFFF, '0, 1'b0, '0});
        plan.push_back('{ROW_WRITE, CFG_LOW, 20'd0, '0, 1'b0, '0});
        plan.push_back('{ROW_WRITE, CFG_TPM, 20'd0, '0, 1'b0, '0});
        plan.push_back('{ROW_SAMPLE, '0, '0, 16'hFFFF, 1'b0, '0});
        plan.push_back('{ROW_SAMPLE, '0, '0, 16'd0, 1'b0, '0});

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                drain_block();
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                send_sample(plan[i].sample, plan[i].pinned, plan[i].want);
            end
        end

        // Random phases, each under its own register setting; the first two
        // run at full rate with no idling on either side
        n_phase = 0;
        while (sent_items < ITEM_TARGET) begin
            drain_block();
            calm = (n_phase < 2);
            n_phase++;
            if (calm || $urandom_range(2, 0) == 0) prof = PROF_NORMAL;
            else prof = cfg_profile_t'($urandom_range(PROF_NORMAL, PROF_TPM_ZERO));
            hi   = SAMPLE_W'($urandom_range(65535, 40000));
            lo   = SAMPLE_W'($urandom_range(30000, 0));
            rate = TPM_W'($urandom_range(200000, 1));
            case (prof)
                PROF_TPM_ZERO:  rate = '0;
                PROF_TPM_MAX:   rate = '1;
                PROF_TPM_ONE:   rate = TPM_W'(1);
                PROF_TPM_TOP:   rate = TPM_W'(1000000);
                PROF_HIGH_ZERO: hi = '0;
                PROF_LOW_FULL:  lo = '1;
                PROF_SWAPPED: begin
                    hi = SAMPLE_W'($urandom_range(30000, 0));
                    lo = SAMPLE_W'($urandom_range(65535, 30001));
                end
                PROF_NO_PEAK:   hi = '1;
                PROF_NO_REARM:  lo = '0;
                default: ;
            endcase
            if ($urandom_range(3, 0) == 0) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
            write_reg(CFG_HIGH, hi);
            write_reg(CFG_LOW, lo);
            write_reg(CFG_TPM, rate);
            // Settings that never close an interval get a short phase
            phase_stop = sent_items +
                         ((prof == PROF_NO_PEAK || prof == PROF_NO_REARM) ? 30 : 200);
            while (sent_items < phase_stop && sent_items < ITEM_TARGET) begin
                if ($urandom_range(99, 0) < 15) begin
                    repeat ($urandom_range(3, 1)) send_sample(SAMPLE_W'($urandom));
                end else begin
                    n_mid = ($urandom_range(9, 0) == 0) ? $urandom_range(80, 10)
                                                       : $urandom_range(6, 0);
                    close_interval($urandom_range(3, 0), n_mid);
                end
            end
        end

        drain_block();
        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### sim.f
sv/pib_pkg.sv
sv/pib_if.sv
sv/pib_front.sv
sv/pib_queue.sv
sv/pib_back.sv
sv/pulse_interval_bpm_averager_top.sv
sv/pib_checker.sv
tb/sv/testbench.sv
